>>> hw/rtl/bsl_pkg.sv
// Shared types and constants for the byte stream lexer.
// Token kind codes, lexer mode enum and character class helpers.
// No dependencies.
`timescale 1ns / 1ps

package bsl_pkg;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SLASH,
    M_COMMENT,
    M_PAIR,
    M_IDENT,
    M_INT,
    M_DECIMAL
  } lex_mode_t;

  typedef logic [5:0] kind_t;

  localparam kind_t K_ADD     = 6'd0;
  localparam kind_t K_SUB     = 6'd1;
  localparam kind_t K_MUL     = 6'd2;
  localparam kind_t K_DIV     = 6'd3;
  localparam kind_t K_MOD     = 6'd4;
  localparam kind_t K_LPAREN  = 6'd5;
  localparam kind_t K_RPAREN  = 6'd6;
  localparam kind_t K_LBRACK  = 6'd7;
  localparam kind_t K_RBRACK  = 6'd8;
  localparam kind_t K_LBRACE  = 6'd9;
  localparam kind_t K_RBRACE  = 6'd10;
  localparam kind_t K_OR      = 6'd11;
  localparam kind_t K_GT      = 6'd13;
  localparam kind_t K_LT      = 6'd15;
  localparam kind_t K_ASSIGN  = 6'd17;
  localparam kind_t K_NOT     = 6'd19;
  localparam kind_t K_TILDE   = 6'd21;
  localparam kind_t K_AND     = 6'd22;
  localparam kind_t K_IF      = 6'd24;
  localparam kind_t K_WHILE   = 6'd25;
  localparam kind_t K_FOR     = 6'd26;
  localparam kind_t K_RETURN  = 6'd27;
  localparam kind_t K_FUNC    = 6'd28;
  localparam kind_t K_IDENT   = 6'd29;
  localparam kind_t K_INT     = 6'd30;
  localparam kind_t K_DECIMAL = 6'd31;
  localparam kind_t K_END     = 6'd32;
  localparam kind_t K_ERROR   = 6'd33;

  // keyword bytes, packed first character highest
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6966;
  localparam logic [47:0] KW_WHILE  = 48'h0077_6869_6c65;
  localparam logic [47:0] KW_FOR    = 48'h0000_0066_6f72;
  localparam logic [47:0] KW_RETURN = 48'h7265_7475_726e;
  localparam logic [47:0] KW_FUNC   = 48'h0000_6675_6e63;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_AMP   = 8'h26;

  localparam int Q_DEPTH = 4;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // {hit, kind} for one-character operators
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      8'h2b:   r = {1'b1, K_ADD};
      8'h2d:   r = {1'b1, K_SUB};
      8'h2a:   r = {1'b1, K_MUL};
      8'h25:   r = {1'b1, K_MOD};
      8'h28:   r = {1'b1, K_LPAREN};
      8'h29:   r = {1'b1, K_RPAREN};
      8'h5b:   r = {1'b1, K_LBRACK};
      8'h5d:   r = {1'b1, K_RBRACK};
      8'h7b:   r = {1'b1, K_LBRACE};
      8'h7d:   r = {1'b1, K_RBRACE};
      8'h7e:   r = {1'b1, K_TILDE};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  // {hit, kind} for operators that may take a second character;
  // the two-character form is kind + 1
  function automatic logic [6:0] pair_kind(input logic [7:0] c);
    logic [6:0] r;
    case (c)
      8'h7c:   r = {1'b1, K_OR};
      8'h3e:   r = {1'b1, K_GT};
      8'h3c:   r = {1'b1, K_LT};
      8'h3d:   r = {1'b1, K_ASSIGN};
      8'h21:   r = {1'b1, K_NOT};
      8'h26:   r = {1'b1, K_AND};
      default: r = 7'd0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/byte_stream_lexer_top.sv
// Byte stream lexer top level: front end lexer feeding a token queue.
// Depends on bsl_pkg, bsl_front, bsl_queue.
// Tokens enter the four-entry token queue as the byte ending them is taken.
// Throughput: one byte per cycle while in_full is low; a byte may end up to two
// tokens, drained at one per cycle while popped (full at three or more held).
// Reset (synchronous, rst_n low): line 1, column 0, idle mode, queue empty.
`timescale 1ns / 1ps

module byte_stream_lexer_top #(
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 31,
  parameter int LENGTH_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  output logic                     in_full,
  input  logic [7:0]               in_src_byte,
  output logic                     out_empty,
  input  logic                     out_pop,
  output logic [5:0]               out_token_kind,
  output logic [POSITION_BITS-1:0] out_line_number,
  output logic [POSITION_BITS-1:0] out_column,
  output logic [LENGTH_BITS-1:0]   out_token_length,
  output logic [VALUE_BITS-1:0]    out_int_value,
  output logic                     out_last_of_run
);

  localparam int TOK_W = 6 + 2 * POSITION_BITS + LENGTH_BITS + VALUE_BITS + 1;

  logic [1:0]       tok_wr;
  logic [TOK_W-1:0] tok0_data, tok1_data, head;

  bsl_front #(
    .POSITION_BITS (POSITION_BITS),
    .VALUE_BITS    (VALUE_BITS),
    .LENGTH_BITS   (LENGTH_BITS),
    .TOK_W         (TOK_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .q_full      (in_full),
    .in_src_byte (in_src_byte),
    .tok_wr      (tok_wr),
    .tok0_data   (tok0_data),
    .tok1_data   (tok1_data)
  );

  bsl_queue #(
    .WIDTH (TOK_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tok_wr),
    .wr0_data (tok0_data),
    .wr1_data (tok1_data),
    .full     (in_full),
    .empty    (out_empty),
    .pop      (out_pop),
    .rd_data  (head)
  );

  assign {out_token_kind, out_line_number, out_column, out_token_length,
          out_int_value, out_last_of_run} = head;

endmodule

>>> hw/rtl/bsl_front.sv
// Lexer front end: takes source bytes, tracks position and mode, and
// forms up to two finished tokens per byte. Uses bsl_pkg.
`timescale 1ns / 1ps

module bsl_front #(
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 31,
  parameter int LENGTH_BITS   = 8,
  parameter int TOK_W = 6 + 2 * POSITION_BITS + LENGTH_BITS + VALUE_BITS + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  logic             q_full,
  input  logic [7:0]       in_src_byte,
  output logic [1:0]       tok_wr,
  output logic [TOK_W-1:0] tok0_data,
  output logic [TOK_W-1:0] tok1_data
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0]   LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0]    VAL_MAX = {VALUE_BITS{1'b1}};
  localparam int                       ACC_W   = VALUE_BITS + 4;

  bsl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [7:0]               pend_r, pend_nxt;
  logic [POSITION_BITS-1:0] line_r, line_nxt;
  logic [POSITION_BITS-1:0] col_r, col_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [LENGTH_BITS-1:0]   run_r, run_nxt;
  logic [VALUE_BITS-1:0]    acc_r, acc_nxt;
  logic [47:0]              kwp_r, kwp_nxt;

  logic                     take;
  logic [7:0]               b;
  logic                     b_letter, b_digit, b_word;
  logic [6:0]               sk, pk, pend_pk;
  logic                     pair_hit, pair_bad, cont;
  logic [POSITION_BITS-1:0] col_inc, line_inc;
  logic [LENGTH_BITS-1:0]   run_inc;
  logic [ACC_W-1:0]         acc_mac;
  logic [VALUE_BITS-1:0]    acc_sat;
  bsl_pkg::kind_t           id_kind;

  logic                     e_v, f_v;
  bsl_pkg::kind_t           e_kind, f_kind;
  logic [LENGTH_BITS-1:0]   e_len, f_len;
  logic [VALUE_BITS-1:0]    e_val, f_val;
  logic [POSITION_BITS-1:0] f_col;

  assign take     = in_push && !q_full;
  assign b        = in_src_byte;
  assign b_letter = bsl_pkg::is_letter(b);
  assign b_digit  = bsl_pkg::is_digit(b);
  assign b_word   = b_letter || b_digit || (b == bsl_pkg::CH_UNDER);
  assign sk       = bsl_pkg::single_kind(b);
  assign pk       = bsl_pkg::pair_kind(b);
  assign pend_pk  = bsl_pkg::pair_kind(pend_r);

  assign col_inc  = (col_r == POS_MAX) ? col_r : col_r + 1'b1;
  assign line_inc = (line_r == POS_MAX) ? line_r : line_r + 1'b1;
  assign run_inc  = (run_r == LEN_MAX) ? run_r : run_r + 1'b1;

  // acc * 10 + digit, saturated; same test as comparing against (max - d) / 10
  assign acc_mac = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1)
                 + ACC_W'(b - bsl_pkg::CH_ZERO);
  assign acc_sat = (acc_mac > ACC_W'(VAL_MAX)) ? VAL_MAX : acc_mac[VALUE_BITS-1:0];

  // second character of a pair: doubled for | and &, '=' for the rest
  always_comb begin
    if (pend_r == bsl_pkg::CH_BAR || pend_r == bsl_pkg::CH_AMP) begin
      pair_hit = (b == pend_r);
    end else begin
      pair_hit = (b == bsl_pkg::CH_EQ);
    end
  end

  // whole-word keyword match
  always_comb begin
    id_kind = bsl_pkg::K_IDENT;
    if (run_r == LENGTH_BITS'(2) && kwp_r == bsl_pkg::KW_IF) begin
      id_kind = bsl_pkg::K_IF;
    end else if (run_r == LENGTH_BITS'(5) && kwp_r == bsl_pkg::KW_WHILE) begin
      id_kind = bsl_pkg::K_WHILE;
    end else if (run_r == LENGTH_BITS'(3) && kwp_r == bsl_pkg::KW_FOR) begin
      id_kind = bsl_pkg::K_FOR;
    end else if (run_r == LENGTH_BITS'(6) && kwp_r == bsl_pkg::KW_RETURN) begin
      id_kind = bsl_pkg::K_RETURN;
    end else if (run_r == LENGTH_BITS'(4) && kwp_r == bsl_pkg::KW_FUNC) begin
      id_kind = bsl_pkg::K_FUNC;
    end
  end

  // cont: the byte is absorbed by the current mode and is not lexed afresh
  always_comb begin
    pair_bad = 1'b0;
    case (mode_r)
      bsl_pkg::M_SLASH:   cont = (b == bsl_pkg::CH_SLASH);
      bsl_pkg::M_COMMENT: cont = (b != bsl_pkg::CH_LF) && (b != bsl_pkg::CH_NUL);
      bsl_pkg::M_PAIR: begin
        pair_bad = !pend_pk[6];
        cont     = pend_pk[6] && pair_hit;
      end
      bsl_pkg::M_IDENT:   cont = b_word;
      bsl_pkg::M_INT:     cont = b_digit || (b == bsl_pkg::CH_DOT);
      bsl_pkg::M_DECIMAL: cont = b_digit;
      default:            cont = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    start_nxt = start_r;
    run_nxt   = run_r;
    acc_nxt   = acc_r;
    kwp_nxt   = kwp_r;
    if (cont) begin
      col_nxt = col_inc;
      case (mode_r)
        bsl_pkg::M_SLASH: mode_nxt = bsl_pkg::M_COMMENT;
        bsl_pkg::M_PAIR:  mode_nxt = bsl_pkg::M_IDLE;
        bsl_pkg::M_IDENT: begin
          if (run_r < LENGTH_BITS'(6)) begin
            kwp_nxt = {kwp_r[39:0], b};
          end
          run_nxt = run_inc;
        end
        bsl_pkg::M_INT: begin
          if (b_digit) begin
            acc_nxt = acc_sat;
          end else begin
            mode_nxt = bsl_pkg::M_DECIMAL;
          end
          run_nxt = run_inc;
        end
        bsl_pkg::M_DECIMAL: run_nxt = run_inc;
        default: ;
      endcase
    end else begin
      mode_nxt = bsl_pkg::M_IDLE;
      if (b == bsl_pkg::CH_NUL) begin
        // end of source: back to the reset state
        pend_nxt  = 8'd0;
        line_nxt  = POSITION_BITS'(1);
        col_nxt   = '0;
        start_nxt = '0;
        run_nxt   = '0;
        acc_nxt   = '0;
        kwp_nxt   = '0;
      end else begin
        col_nxt = col_inc;
        if (b == bsl_pkg::CH_LF) begin
          line_nxt = line_inc;
          col_nxt  = '0;
        end else if (b == bsl_pkg::CH_SPACE || sk[6]) begin
          // separator or finished on the spot
        end else if (b == bsl_pkg::CH_SLASH) begin
          mode_nxt  = bsl_pkg::M_SLASH;
          start_nxt = col_inc;
        end else if (pk[6]) begin
          mode_nxt  = bsl_pkg::M_PAIR;
          pend_nxt  = b;
          start_nxt = col_inc;
        end else if (b_letter) begin
          mode_nxt  = bsl_pkg::M_IDENT;
          start_nxt = col_inc;
          run_nxt   = LENGTH_BITS'(1);
          kwp_nxt   = {40'd0, b};
        end else if (b_digit) begin
          mode_nxt  = bsl_pkg::M_INT;
          start_nxt = col_inc;
          run_nxt   = LENGTH_BITS'(1);
          acc_nxt   = VALUE_BITS'(b - bsl_pkg::CH_ZERO);
        end
      end
    end
  end

  // outputs: e_* is the token the byte ends, f_* the token of the byte itself
  always_comb begin
    e_v    = 1'b0;
    e_kind = bsl_pkg::K_DIV;
    e_len  = LENGTH_BITS'(1);
    e_val  = '0;
    case (mode_r)
      bsl_pkg::M_SLASH: e_v = !cont;
      bsl_pkg::M_PAIR: begin
        e_v    = !pair_bad;
        e_kind = cont ? pend_pk[5:0] + 1'b1 : pend_pk[5:0];
        e_len  = cont ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
      end
      bsl_pkg::M_IDENT: begin
        e_v    = !cont;
        e_kind = id_kind;
        e_len  = run_r;
      end
      bsl_pkg::M_INT: begin
        e_v    = !cont;
        e_kind = bsl_pkg::K_INT;
        e_len  = run_r;
        e_val  = acc_r;
      end
      bsl_pkg::M_DECIMAL: begin
        e_v    = !cont;
        e_kind = bsl_pkg::K_DECIMAL;
        e_len  = run_r;
      end
      default: ;
    endcase

    f_v    = 1'b0;
    f_kind = bsl_pkg::K_ERROR;
    f_col  = col_inc;
    f_len  = LENGTH_BITS'(1);
    f_val  = VALUE_BITS'(b);
    if (!cont) begin
      if (b == bsl_pkg::CH_NUL) begin
        f_v    = 1'b1;
        f_kind = bsl_pkg::K_END;
        f_len  = '0;
        f_val  = '0;
      end else if (sk[6]) begin
        f_v    = 1'b1;
        f_kind = sk[5:0];
        f_val  = '0;
      end else if (b != bsl_pkg::CH_LF && b != bsl_pkg::CH_SPACE
                   && b != bsl_pkg::CH_SLASH && !pk[6] && !b_letter && !b_digit) begin
        f_v = 1'b1;
      end
    end

    tok0_data = {e_kind, line_r, start_r, e_len, e_val, !f_v};
    tok1_data = {f_kind, line_r, f_col, f_len, f_val, 1'b1};
    tok_wr    = 2'b00;
    if (take) begin
      if (e_v) begin
        tok_wr = {f_v, 1'b1};
      end else if (f_v) begin
        tok0_data = tok1_data;
        tok_wr    = 2'b01;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bsl_pkg::M_IDLE;
      pend_r  <= 8'd0;
      line_r  <= POSITION_BITS'(1);
      col_r   <= '0;
      start_r <= '0;
      run_r   <= '0;
      acc_r   <= '0;
      kwp_r   <= '0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      start_r <= start_nxt;
      run_r   <= run_nxt;
      acc_r   <= acc_nxt;
      kwp_r   <= kwp_nxt;
    end
  end

endmodule

>>> hw/rtl/bsl_queue.sv
// Token queue between the lexer front end and the result port.
// Takes up to two tokens per cycle, hands out one. Uses bsl_pkg.
`timescale 1ns / 1ps

module bsl_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       wr,
  input  logic [WIDTH-1:0] wr0_data,
  input  logic [WIDTH-1:0] wr1_data,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data
);

  localparam int DEPTH = bsl_pkg::Q_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             take;
  logic [PTR_W-1:0] wptr_p1;

  assign empty   = (cnt_r == '0);
  // room for two is kept so a byte that ends two tokens never stalls mid-way
  assign full    = (cnt_r > CNT_W'(DEPTH - 2));
  assign take    = pop && !empty;
  assign rd_data = mem_r[rptr_r];
  assign wptr_p1 = wptr_r + 1'b1;

  always_comb begin
    wptr_nxt = wptr_r + PTR_W'(wr[0]) + PTR_W'(wr[1]);
    rptr_nxt = take ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r + CNT_W'(wr[0]) + CNT_W'(wr[1]) - CNT_W'(take);
  end

  always_ff @(posedge clk) begin
    if (wr[0]) begin
      mem_r[wptr_r] <= wr0_data;
    end
    if (wr[1]) begin
      mem_r[wptr_p1] <= wr1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("token queue count overflow");

  a_slot_order: assert property (@(posedge clk) disable iff (!rst_n)
    wr[1] |-> wr[0])
    else $error("second token written without first");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> (wr == 2'b00))
    else $error("token written while queue full");

  a_pop_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (take && wr == 2'b00) |=> (cnt_r == $past(cnt_r) - 1'b1))
    else $error("pop did not drain queue");

endmodule

>>> tb/byte_stream_lexer_checker.sv
// Token checker for the byte stream lexer: watches both queue ports,
// predicts the tokens of every accepted source byte and compares them in order.
// Depends on bsl_pkg (kind codes, mode enum, character constants).
`timescale 1ns / 1ps

module byte_stream_lexer_checker #(
  parameter int POSITION_BITS = 16,
  parameter int VALUE_BITS    = 31,
  parameter int LENGTH_BITS   = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  logic                     in_full,
  input  logic [7:0]               in_src_byte,
  input  logic                     out_empty,
  input  logic                     out_pop,
  input  logic [5:0]               out_token_kind,
  input  logic [POSITION_BITS-1:0] out_line_number,
  input  logic [POSITION_BITS-1:0] out_column,
  input  logic [LENGTH_BITS-1:0]   out_token_length,
  input  logic [VALUE_BITS-1:0]    out_int_value,
  input  logic                     out_last_of_run,
  output int                       fail_count,
  output int                       open_count
);

  import bsl_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_TOP = '1;
  localparam logic [LENGTH_BITS-1:0]   LEN_TOP = '1;
  localparam logic [VALUE_BITS-1:0]    VAL_TOP = '1;

  typedef struct {
    kind_t                     kind;
    logic [POSITION_BITS-1:0]  line;
    logic [POSITION_BITS-1:0]  col;
    logic [LENGTH_BITS-1:0]    len;
    logic [VALUE_BITS-1:0]     val;
    logic                      last;
  } token_t;

  token_t expected_tokens[$];
  token_t head_tok;
  int bad = 0;

  // lexer state as seen from outside
  lex_mode_t                mode;
  logic [7:0]               held_op;
  logic [POSITION_BITS-1:0] row;
  logic [POSITION_BITS-1:0] col;
  logic [POSITION_BITS-1:0] tok_col;
  logic [LENGTH_BITS-1:0]   tok_len;
  logic [VALUE_BITS-1:0]    acc;
  logic [47:0]              ident_head;

  function void clear_state();
    mode = M_IDLE;
    held_op = '0;
    row = 1;
    col = '0;
    tok_col = '0;
    tok_len = '0;
    acc = '0;
    ident_head = '0;
  endfunction

  function automatic logic [POSITION_BITS-1:0] pos_inc(input logic [POSITION_BITS-1:0] v);
    return (v == POS_TOP) ? v : v + 1'b1;
  endfunction

  function automatic logic [LENGTH_BITS-1:0] len_inc(input logic [LENGTH_BITS-1:0] v);
    return (v == LEN_TOP) ? v : v + 1'b1;
  endfunction

  function automatic bit alpha(input logic [7:0] c);
    return ((c | 8'h20) >= "a") && ((c | 8'h20) <= "z");
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit single_op(input logic [7:0] c, output kind_t k);
    k = K_ERROR;
    case (c)
      "+": k = K_ADD;
      "-": k = K_SUB;
      "*": k = K_MUL;
      "%": k = K_MOD;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      "~": k = K_TILDE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // operators that may pair up; the doubled form is one kind higher
  function automatic bit pair_op(input logic [7:0] c, output kind_t k, output logic [7:0] sec);
    sec = CH_EQ;
    k = K_ERROR;
    case (c)
      "|": begin
        k = K_OR;
        sec = CH_BAR;
      end
      "&": begin
        k = K_AND;
        sec = CH_AMP;
      end
      ">": k = K_GT;
      "<": k = K_LT;
      "=": k = K_ASSIGN;
      "!": k = K_NOT;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic kind_t word_kind(input logic [LENGTH_BITS-1:0] n, input logic [47:0] head);
    case (n)
      2: if (head == {32'd0, "if"}) return K_IF;
      3: if (head == {24'd0, "for"}) return K_FOR;
      4: if (head == {16'd0, "func"}) return K_FUNC;
      5: if (head == {8'd0, "while"}) return K_WHILE;
      6: if (head == "return") return K_RETURN;
      default: ;
    endcase
    return K_IDENT;
  endfunction

  function void post(input kind_t k, input logic [POSITION_BITS-1:0] ln,
                     input logic [POSITION_BITS-1:0] c, input logic [LENGTH_BITS-1:0] len,
                     input logic [VALUE_BITS-1:0] v);
    token_t t;
    t.kind = k;
    t.line = ln;
    t.col  = c;
    t.len  = len;
    t.val  = v;
    t.last = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  // one source byte: finish the pending token if this byte ends it, then start the next
  function void lex_byte(input logic [7:0] b);
    int first;
    bit done;
    kind_t k;
    logic [7:0] sec;
    longint unsigned wide;
    longint unsigned d;
    first = expected_tokens.size();
    done = 1'b0;
    case (mode)
      M_SLASH: begin
        if (b == CH_SLASH) begin
          col = pos_inc(col);
          mode = M_COMMENT;
          done = 1'b1;
        end else begin
          post(K_DIV, row, tok_col, 1, 0);
        end
      end
      M_COMMENT: begin
        if (b != CH_LF && b != CH_NUL) begin
          col = pos_inc(col);
          done = 1'b1;
        end
      end
      M_PAIR: begin
        void'(pair_op(held_op, k, sec));
        if (b == sec) begin
          col = pos_inc(col);
          post(k + 6'd1, row, tok_col, 2, 0);
          mode = M_IDLE;
          done = 1'b1;
        end else begin
          post(k, row, tok_col, 1, 0);
        end
      end
      M_IDENT: begin
        if (alpha(b) || numeral(b) || b == CH_UNDER) begin
          col = pos_inc(col);
          if (tok_len < 6) ident_head = {ident_head[39:0], b};
          tok_len = len_inc(tok_len);
          done = 1'b1;
        end else begin
          post(word_kind(tok_len, ident_head), row, tok_col, tok_len, 0);
        end
      end
      M_INT: begin
        if (numeral(b)) begin
          d = b - CH_ZERO;
          wide = acc;
          col = pos_inc(col);
          if (wide > (VAL_TOP - d) / 10) acc = VAL_TOP;
          else acc = wide * 10 + d;
          tok_len = len_inc(tok_len);
          done = 1'b1;
        end else if (b == CH_DOT) begin
          col = pos_inc(col);
          tok_len = len_inc(tok_len);
          mode = M_DECIMAL;
          done = 1'b1;
        end else begin
          post(K_INT, row, tok_col, tok_len, acc);
        end
      end
      M_DECIMAL: begin
        if (numeral(b)) begin
          col = pos_inc(col);
          tok_len = len_inc(tok_len);
          done = 1'b1;
        end else begin
          post(K_DECIMAL, row, tok_col, tok_len, 0);
        end
      end
      default: ;
    endcase

    if (!done) begin
      mode = M_IDLE;
      if (b == CH_NUL) begin
        post(K_END, row, pos_inc(col), 0, 0);
        clear_state();
      end else begin
        col = pos_inc(col);
        if (b == CH_LF) begin
          row = pos_inc(row);
          col = '0;
        end else if (b == CH_SPACE) begin
        end else if (single_op(b, k)) begin
          post(k, row, col, 1, 0);
        end else if (b == CH_SLASH) begin
          mode = M_SLASH;
          tok_col = col;
        end else if (pair_op(b, k, sec)) begin
          mode = M_PAIR;
          held_op = b;
          tok_col = col;
        end else if (alpha(b)) begin
          mode = M_IDENT;
          tok_col = col;
          tok_len = 1;
          ident_head = {40'd0, b};
        end else if (numeral(b)) begin
          mode = M_INT;
          tok_col = col;
          tok_len = 1;
          acc = b - CH_ZERO;
        end else begin
          post(K_ERROR, row, col, 1, b);
        end
      end
    end

    if (expected_tokens.size() > first) expected_tokens[$].last = 1'b1;
  endfunction

  function void compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      bad++;
    end
  endfunction

  function void check_token();
    if (expected_tokens.size() == 0) begin
      $display("%0t: token kind %0d at line %0d col %0d with no request behind it",
               $time, out_token_kind, out_line_number, out_column);
      bad++;
    end else begin
      head_tok = expected_tokens.pop_front();
      compare_field("token_kind", head_tok.kind, out_token_kind);
      compare_field("line_number", head_tok.line, out_line_number);
      compare_field("column", head_tok.col, out_column);
      compare_field("token_length", head_tok.len, out_token_length);
      compare_field("int_value", head_tok.val, out_int_value);
      compare_field("last_of_run", head_tok.last, out_last_of_run);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      expected_tokens.delete();
    end else begin
      // a token can leave the queue no earlier than the cycle after its byte, so check first
      if (out_pop && !out_empty) check_token();
      if (in_push && !in_full) lex_byte(in_src_byte);
    end
    fail_count <= bad;
    open_count <= expected_tokens.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for byte_stream_lexer_top: clock, reset, source byte stimulus
// and random token draining; checking lives in byte_stream_lexer_checker.
// Depends on bsl_pkg, byte_stream_lexer_top, byte_stream_lexer_checker.
`timescale 1ns / 1ps

module tb;

  import bsl_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 900;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic [7:0]  in_src_byte = 8'd0;
  logic        out_pop = 1'b0;
  logic        in_full;
  logic        out_empty;
  logic [5:0]  out_token_kind;
  logic [15:0] out_line_number;
  logic [15:0] out_column;
  logic [7:0]  out_token_length;
  logic [30:0] out_int_value;
  logic        out_last_of_run;

  int  errors;
  int  pending;
  int  cycles = 0;
  int  bytes_sent = 0;
  bit  steady = 1'b0;
  string keywords[5] = '{"if", "while", "for", "return", "func"};

  always #5 clk = ~clk;

  byte_stream_lexer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_src_byte      (in_src_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_column       (out_column),
    .out_token_length (out_token_length),
    .out_int_value    (out_int_value),
    .out_last_of_run  (out_last_of_run)
  );

  byte_stream_lexer_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_src_byte      (in_src_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_column       (out_column),
    .out_token_length (out_token_length),
    .out_int_value    (out_int_value),
    .out_last_of_run  (out_last_of_run),
    .fail_count       (errors),
    .open_count       (pending)
  );

  always @(posedge clk) out_pop <= steady || ($urandom_range(99) >= 35);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[byte_stream_lexer_top] ERROR");
      $finish;
    end
  end

  // returns at the edge where the request is taken
  task automatic send_byte(input logic [7:0] b);
    if (!steady && $urandom_range(99) < 35) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_src_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_rep(input logic [7:0] b, input int n);
    repeat (n) send_byte(b);
  endtask

  function automatic logic [7:0] pick_letter();
    return 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(CH_ZERO + $urandom_range(9));
  endfunction

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(9);
    if (r < 6) return pick_letter();
    if (r < 9) return pick_digit();
    return CH_UNDER;
  endfunction

  // one random lexeme, mostly well formed, followed by an optional separator
  task automatic send_token();
    int pick;
    int i;
    logic [7:0] c;
    string word;
    string ops;
    ops = "+-*%()[]{}~|><=!&/";
    pick = $urandom_range(99);
    if (pick < 12) begin
      word = keywords[$urandom_range(4)];
      case ($urandom_range(9))
        0: word = {word, "s"};
        1: word = word.substr(0, word.len() - 2);
        2: word = {word, "_1"};
        default: ;
      endcase
      send_text(word);
    end else if (pick < 27) begin
      send_byte(pick_letter());
      repeat ($urandom_range(8)) send_byte(pick_word_char());
    end else if (pick < 39) begin
      repeat ($urandom_range(1, 12)) send_byte(pick_digit());
    end else if (pick < 46) begin
      repeat ($urandom_range(1, 4)) send_byte(pick_digit());
      send_byte(CH_DOT);
      repeat ($urandom_range(4)) send_byte(pick_digit());
      if ($urandom_range(9) == 0) begin
        send_byte(CH_DOT);
        send_byte(pick_digit());
      end
    end else if (pick < 70) begin
      i = $urandom_range(ops.len() - 1);
      c = ops[i];
      send_byte(c);
      // positions 11..16 hold the operators that can take a second character
      if (i >= 11 && i <= 16 && $urandom_range(1))
        send_byte((c == CH_BAR || c == CH_AMP) ? c : CH_EQ);
    end else if (pick < 76) begin
      send_text("//");
      repeat ($urandom_range(15)) begin
        c = 8'($urandom_range(1, 255));
        send_byte(c == CH_LF ? "x" : c);
      end
      send_byte($urandom_range(9) ? CH_LF : CH_NUL);
    end else if (pick < 87) begin
      send_byte(8'($urandom_range(1, 255)));
    end else if (pick < 90) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(CH_UNDER);
    end
    pick = $urandom_range(99);
    if (pick < 55) send_byte(CH_SPACE);
    else if (pick < 70) send_byte(CH_LF);
  endtask

  initial begin
    int target;
    int waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // keywords, near misses, every operator, number forms, comments, stray bytes
    send_text("if while for return func iff whil returns _ a_1 Z9z\n");
    send_text("+-*%()[]{}~ | || > >= < <= = == ! != & && &|=>!<\n");
    send_text("0 3.14 5. 7.8.9 2147483646 2147483647 2147483648 a/b // note\n/ /x\n");
    send_text("\t\r@#$`._\"");
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(8'h7f);
    send_byte(8'h01);
    // end of source in the middle of each kind of token, and an empty source
    send_text("abc");
    send_byte(CH_NUL);
    send_text("/");
    send_byte(CH_NUL);
    send_text(">");
    send_byte(CH_NUL);
    send_text("//c");
    send_byte(CH_NUL);
    send_text("5");
    send_byte(CH_NUL);
    send_text("5.");
    send_byte(CH_NUL);
    send_byte(CH_NUL);

    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      steady = (target - bytes_sent) inside {[300:500]};
      send_token();
    end

    // saturation of token length and integer value
    steady = 1'b1;
    send_byte(CH_NUL);
    send_rep("q", 300);
    send_byte(CH_SPACE);
    send_rep("7", 260);
    send_text(" 1.");
    send_rep("5", 300);
    send_byte(CH_SPACE);
    send_byte(CH_LF);
    send_text("x ");
    send_text("y+");
    send_byte(CH_NUL);
    steady = 1'b0;
    in_push <= 1'b0;

    @(posedge clk);
    waited = 0;
    while (pending != 0 && waited < 10000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("[byte_stream_lexer_top] OK");
    else
      $display("[byte_stream_lexer_top] ERROR");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/bsl_pkg.sv
hw/rtl/bsl_front.sv
hw/rtl/bsl_queue.sv
hw/rtl/byte_stream_lexer_top.sv
tb/byte_stream_lexer_checker.sv
tb/tb.sv
